FILE: sv/ccst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccst_pkg - shared types for the connection close state tracker
// State and event codes, sent/received flag positions, table entry layout.
// ----------------------------------------------------------------------------
package ccst_pkg;

  localparam int CONN_W      = 8;
  localparam int CONNECTIONS = 256;
  localparam int ADDR_W      = $clog2(CONNECTIONS);

  typedef enum logic [3:0] {
    ST_INIT       = 4'd0,
    ST_LISTEN     = 4'd1,
    ST_ACTIVE     = 4'd2,
    ST_PCW1       = 4'd3,
    ST_PCW2       = 4'd4,
    ST_APPFIN     = 4'd5,
    ST_ACW1       = 4'd6,
    ST_ACW2       = 4'd7,
    ST_PEERFIN    = 4'd8,
    ST_PEERABORT  = 4'd9,
    ST_PROCABORT  = 4'd10,
    ST_CLOSED     = 4'd11
  } close_state_e;

  typedef enum logic [2:0] {
    OP_CLOSE   = 3'd0,
    OP_SHUT_WR = 3'd1,
    OP_PEER    = 3'd2,
    OP_ABORT   = 3'd3,
    OP_LOAD    = 3'd4
  } opcode_e;

  // sent flag bit positions
  localparam int TX_DW = 0;
  localparam int TX_CC = 1;
  localparam int TX_CA = 2;
  // received flag bit positions
  localparam int RX_CC = 0;
  localparam int RX_CA = 1;

  typedef struct packed {
    logic [3:0] state;
    logic [2:0] tx;
    logic [1:0] rx;
    logic       dead;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]        opcode;
    logic [CONN_W-1:0] connection;
    logic              rx_done_writing;
    logic              rx_conn_closed;
    logic              rx_conn_abort;
    logic              pending_rx_data;
    logic              killed;
    logic              released_locally;
    logic [3:0]        load_value;
  } event_t;

  typedef struct packed {
    logic [3:0] new_state;
    logic       send_message;
    logic       tx_done_writing;
    logic       tx_conn_closed;
    logic       tx_conn_abort;
    logic       broken_pipe;
    logic       shutdown_tcp;
    logic       free_connection;
    logic       release_tcp;
    logic       drop_reference;
    logic       state_changed;
  } result_t;

endpackage

FILE: sv/ccst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccst_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ccst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/connection_close_state_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_close_state_tracker - per-connection close state machine table
// Applies close events to a 256-entry table and reports the resulting
// state, close message flags and follow-up actions.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request is registered in the input stage, its result in the result stage.
// Throughput: one request per cycle unless the output stalls; the table RAM is
//   read at accept and written back when the request advances, a write-back
//   register forwards the newest entry to a request on the same connection.
// Reset: entry valid bits clear at once, so every entry reads as INIT with
//   no flags; no clearing pass, the block is ready right after reset.
module connection_close_state_tracker
  import ccst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] connection, [8] rx_done_writing, [9] rx_conn_closed,
  // [10] rx_conn_abort, [11] pending_rx_data, [12] killed,
  // [13] released_locally, [17:14] load_value, [23:18] zero
  input  logic [23:0] s_axis_tdata_i,
  // [2:0] opcode
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] new_state, [4] send_message, [5] tx_done_writing,
  // [6] tx_conn_closed, [7] tx_conn_abort, [8] broken_pipe, [9] shutdown_tcp,
  // [10] free_connection, [11] release_tcp, [12] drop_reference,
  // [13] state_changed, [15:14] zero
  output logic [15:0] m_axis_tdata_o
);

  logic                   s1_valid_q;
  event_t                 s1_q;
  logic                   out_valid_q;
  result_t                out_q;
  logic [CONNECTIONS-1:0] valid_q;
  logic                   wb_valid_q;
  logic [ADDR_W-1:0]      wb_addr_q;
  entry_t                 wb_data_q;

  logic                   in_accept;
  logic                   advance;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [ADDR_W-1:0]      s1_addr;
  entry_t                 cur;
  entry_t                 nxt;
  result_t                res;

  assign advance         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_addr         = s1_q.connection[ADDR_W-1:0];

  ccst_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CONNECTIONS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (advance),
    .waddr_i(s1_addr),
    .wdata_i(nxt),
    .re_i   (in_accept),
    .raddr_i(s_axis_tdata_i[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // newest copy of the entry: write-back register, else RAM, else reset value
  always_comb begin
    if (wb_valid_q && (wb_addr_q == s1_addr)) begin
      cur = wb_data_q;
    end else if (valid_q[s1_addr]) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  // event evaluation
  always_comb begin
    logic [3:0] st;
    logic [2:0] tx;
    logic [1:0] rx;
    logic       dead_m;
    logic [2:0] fc_tx;
    logic       half_closed;
    logic       sent_close;
    logic       dead;
    logic       anyrx;
    logic       send;
    logic       epipe;
    logic       shut;
    logic       fr;
    logic       reltcp;
    logic       drop;

    st     = cur.state;
    tx     = cur.tx;
    rx     = cur.rx;
    dead_m = cur.dead;
    send   = 1'b0;
    epipe  = 1'b0;
    shut   = 1'b0;
    fr     = 1'b0;
    reltcp = 1'b0;
    drop   = 1'b0;
    dead   = cur.dead || s1_q.released_locally;
    anyrx  = 1'b0;

    sent_close  = cur.tx[TX_CC] || cur.tx[TX_CA];
    half_closed = cur.tx[TX_DW] && !sent_close;
    fc_tx       = cur.tx;
    if (s1_q.pending_rx_data) begin
      fc_tx[TX_CA] = 1'b1;
    end else begin
      fc_tx[TX_CC] = 1'b1;
    end

    unique case (s1_q.opcode)
      OP_CLOSE: begin
        case (cur.state) inside
          ST_INIT: st = ST_CLOSED;
          ST_LISTEN: begin
            st   = ST_CLOSED;
            shut = 1'b1;
          end
          ST_ACTIVE: begin
            tx    = fc_tx;
            send  = !s1_q.killed;
            epipe = s1_q.killed;
            st    = ST_PCW1;
            shut  = 1'b1;
          end
          ST_APPFIN: begin
            if (half_closed) begin
              tx    = fc_tx;
              send  = !s1_q.killed;
              epipe = s1_q.killed;
            end
            st = ST_CLOSED;
          end
          ST_ACW1, ST_ACW2: begin
            tx    = fc_tx;
            send  = !s1_q.killed;
            epipe = s1_q.killed;
            if (cur.rx != 2'b00) begin
              st   = ST_CLOSED;
              drop = 1'b1;
            end else begin
              st = ST_PEERFIN;
            end
          end
          ST_PCW1, ST_PCW2: begin
            if (half_closed) begin
              tx    = fc_tx;
              send  = !s1_q.killed;
              epipe = s1_q.killed;
            end
          end
          ST_PROCABORT: begin
            tx[TX_CA] = 1'b1;
            send      = 1'b1;
            st        = ST_CLOSED;
          end
          ST_PEERABORT: begin
            st   = ST_CLOSED;
            drop = 1'b1;
          end
          default: ;
        endcase
      end
      OP_SHUT_WR: begin
        if (cur.state == ST_ACTIVE) begin
          tx[TX_DW] = 1'b1;
          send      = 1'b1;
          st        = ST_PCW1;
        end else if (cur.state == ST_ACW1) begin
          tx[TX_DW] = 1'b1;
          send      = 1'b1;
          st        = ST_ACW2;
        end
      end
      OP_PEER: begin
        rx[RX_CC] = cur.rx[RX_CC] || s1_q.rx_conn_closed;
        rx[RX_CA] = cur.rx[RX_CA] || s1_q.rx_conn_abort;
        anyrx     = rx[RX_CC] || rx[RX_CA];
        if (rx[RX_CA]) begin
          case (cur.state) inside
            ST_INIT, ST_ACTIVE, ST_ACW1: begin
              st   = ST_PROCABORT;
              drop = 1'b1;
            end
            ST_APPFIN: st = ST_PROCABORT;
            ST_PCW1, ST_PCW2: begin
              st   = half_closed ? ST_PROCABORT : ST_CLOSED;
              drop = 1'b1;
            end
            ST_ACW2, ST_PEERFIN, ST_PEERABORT: begin
              st   = ST_CLOSED;
              drop = 1'b1;
            end
            default: ;
          endcase
        end else begin
          case (cur.state) inside
            ST_INIT, ST_ACTIVE: st = ST_ACW1;
            ST_PCW1, ST_PCW2: begin
              if (cur.state == ST_PCW1 && s1_q.rx_done_writing) begin
                st = ST_PCW2;
              end
              if (anyrx) begin
                st   = (dead && sent_close) ? ST_CLOSED : ST_APPFIN;
                drop = 1'b1;
              end
            end
            ST_PEERFIN: begin
              if (anyrx) begin
                st   = ST_CLOSED;
                drop = 1'b1;
              end
            end
            default: ;
          endcase
        end
        if ((st != cur.state) && (st == ST_CLOSED) && dead) begin
          fr     = 1'b1;
          reltcp = 1'b1;
        end
      end
      OP_ABORT: begin
        case (cur.state) inside
          ST_ACTIVE, ST_ACW1, ST_ACW2: begin
            st   = ST_CLOSED;
            fr   = 1'b1;
            drop = 1'b1;
          end
          ST_PCW1, ST_PCW2, ST_PEERFIN: begin
            st     = ST_CLOSED;
            fr     = 1'b1;
            reltcp = 1'b1;
            drop   = 1'b1;
          end
          ST_PROCABORT, ST_APPFIN: begin
            st     = ST_CLOSED;
            fr     = 1'b1;
            reltcp = 1'b1;
          end
          default: ;
        endcase
        dead_m = 1'b1;
      end
      OP_LOAD: begin
        // out-of-range load keeps the state but still clears the flags
        if (s1_q.load_value <= ST_CLOSED) begin
          st = s1_q.load_value;
        end
        tx     = '0;
        rx     = '0;
        dead_m = 1'b0;
      end
      default: ;
    endcase

    nxt.state = st;
    nxt.tx    = tx;
    nxt.rx    = rx;
    nxt.dead  = dead_m;

    res.new_state       = st;
    res.send_message    = send;
    res.tx_done_writing = tx[TX_DW];
    res.tx_conn_closed  = tx[TX_CC];
    res.tx_conn_abort   = tx[TX_CA];
    res.broken_pipe     = epipe;
    res.shutdown_tcp    = shut;
    res.free_connection = fr;
    res.release_tcp     = reltcp;
    res.drop_reference  = drop;
    res.state_changed   = (st != cur.state);
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.opcode           <= s_axis_tuser_i;
      s1_q.connection       <= s_axis_tdata_i[7:0];
      s1_q.rx_done_writing  <= s_axis_tdata_i[8];
      s1_q.rx_conn_closed   <= s_axis_tdata_i[9];
      s1_q.rx_conn_abort    <= s_axis_tdata_i[10];
      s1_q.pending_rx_data  <= s_axis_tdata_i[11];
      s1_q.killed           <= s_axis_tdata_i[12];
      s1_q.released_locally <= s_axis_tdata_i[13];
      s1_q.load_value       <= s_axis_tdata_i[17:14];
    end
  end

  // result stage, entry valid bits and write-back forwarding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      wb_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q      <= 1'b1;
        valid_q[s1_addr] <= 1'b1;
        wb_valid_q       <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q     <= res;
      wb_addr_q <= s1_addr;
      wb_data_q <= nxt;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00,
                            out_q.state_changed,
                            out_q.drop_reference,
                            out_q.release_tcp,
                            out_q.free_connection,
                            out_q.shutdown_tcp,
                            out_q.broken_pipe,
                            out_q.tx_conn_abort,
                            out_q.tx_conn_closed,
                            out_q.tx_done_writing,
                            out_q.send_message,
                            out_q.new_state};

  // forwarded entry always has its valid bit set
  a_wb_marked_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_valid_q |-> valid_q[wb_addr_q])
    else $error("write-back entry not marked valid");

  // a request is refused only when both stages are full and the output stalls
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s1_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("request refused without backpressure");

  // a refused final close never sends a message
  a_epipe_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.broken_pipe && out_q.send_message))
    else $error("broken pipe with close message");

  // freeing the connection only ever happens on the way to CLOSED
  a_free_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.free_connection) |-> (out_q.new_state == ST_CLOSED))
    else $error("connection freed outside CLOSED");

endmodule
